### src/bms_pkg.sv
// Shared types, codes and constants for the button mode selector.
package bms_pkg;

  // item op codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_PIN  = 2'd1;
  localparam logic [1:0] OP_ARM  = 2'd2;

  // status codes
  localparam logic [1:0] ST_SLEEP  = 2'd0;
  localparam logic [1:0] ST_WAIT   = 2'd1;
  localparam logic [1:0] ST_NOSEL  = 2'd2;
  localparam logic [1:0] ST_NEWSEL = 2'd3;

  // phase codes
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_PRESS    = 2'd1;
  localparam logic [1:0] PH_ANNOUNCE = 2'd2;
  localparam logic [1:0] PH_RELEASE  = 2'd3;

  // config register indexes
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_BEEP = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SHORT_BEEP = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PAUSE     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SEL_TMO   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_MODE  = 3'd5;

  // width of the announce timeout sum before saturation
  localparam int SUM_W = 17;

  typedef struct packed {
    logic [1:0] op;
    logic       pin_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  mode;
    logic        beep_start;
    logic [4:0]  beep_count;
    logic [10:0] beep_on_ms;
    logic [9:0]  beep_gap_ms;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  debounce_ms;
    logic [10:0] long_beep_ms;
    logic [9:0]  short_beep_ms;
    logic [9:0]  beep_pause_ms;
    logic [14:0] selection_timeout_ms;
    logic [3:0]  max_mode;
  } cfg_t;

endpackage

### src/button_mode_selector.sv
// Top level of the button mode selector: item/result registers and handshakes.
//
//   channel   signals                            dir   accepted when
//   item      item_valid, item_ready, item       in    item_valid & item_ready
//   result    result_valid, result_ready, result out   result_valid & result_ready
//   config    cfg_we, cfg_addr, cfg_data         in    cfg_we
//
// One item per clock sustained while results are taken without stall; an
// accepted item waits in the input register, then its result is loaded
// into the result register when that register is empty or being drained.
// The announce timeout multiply-add sits in the single update-logic stage.
// Synchronous active-high rst clears state, timer, mode and config to defaults.
// A stalled result holds the pipe; the input register still takes an item
// while the result register waits, then item_ready drops until result drains.
module button_mode_selector #(
  parameter int TIMER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  bms_pkg::in_item_t               item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output bms_pkg::out_item_t              result,
  input  logic                            cfg_we,
  input  logic [bms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bms_pkg::*;

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_q_valid;
  logic      advance;
  out_item_t result_next;

  // stage advances when the result register is empty or being drained
  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  bms_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  bms_ctrl #(
    .TIMER_BITS (TIMER_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (result_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) item_q <= item;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= result_next;
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    item_q_valid && result_valid && !result_ready |=> item_q_valid)
    else $error("buffered item lost during stall");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance |-> !result_valid || result_ready)
    else $error("result overwritten before taken");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !item_q_valid |-> item_ready)
    else $error("input blocked while empty");

endmodule

### src/bms_cfg.sv
// Configuration register bank for the button mode selector.
module bms_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bms_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bms_pkg::cfg_t                   cfg
);
  import bms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms          <= 10'd50;
      cfg.long_beep_ms         <= 11'd500;
      cfg.short_beep_ms        <= 10'd100;
      cfg.beep_pause_ms        <= 10'd100;
      cfg.selection_timeout_ms <= 15'd1000;
      cfg.max_mode             <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE:   cfg.debounce_ms          <= cfg_data[9:0];
        REG_LONG_BEEP:  cfg.long_beep_ms         <= cfg_data[10:0];
        REG_SHORT_BEEP: cfg.short_beep_ms        <= cfg_data[9:0];
        REG_PAUSE:      cfg.beep_pause_ms        <= cfg_data[9:0];
        REG_SEL_TMO:    cfg.selection_timeout_ms <= cfg_data[14:0];
        REG_MAX_MODE:   cfg.max_mode             <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

### src/bms_ctrl.sv
// Selection state machine, one-shot timer and beep command logic.
module bms_ctrl #(
  parameter int TIMER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  bms_pkg::in_item_t   item,
  input  bms_pkg::cfg_t       cfg,
  output bms_pkg::out_item_t  result
);
  import bms_pkg::*;

  localparam int CMP_W = (TIMER_BITS > SUM_W) ? TIMER_BITS : SUM_W;
  localparam logic [CMP_W-1:0] TMAX = CMP_W'((64'd1 << TIMER_BITS) - 64'd1);

  logic [1:0]            phase, phase_next;
  logic [TIMER_BITS-1:0] countdown, countdown_next;
  logic [3:0]            mode_value, mode_next;
  logic [1:0]            status_reg, status_next;
  logic                  armed, armed_next;

  logic                  do_announce, load_debounce;
  logic [4:0]            mode_inc;
  logic [3:0]            mode_adv;
  logic [4:0]            beep_n;
  logic [10:0]           unit_ms;
  logic [15:0]           beeps_ms;
  logic [SUM_W-1:0]      ann_sum;
  logic [CMP_W-1:0]      ann_ext;
  logic [TIMER_BITS-1:0] ann_load;
  logic [TIMER_BITS-1:0] deb_load;

  // advanced mode, wraps past max_mode
  assign mode_inc = {1'b0, mode_value} + 5'd1;
  assign mode_adv = (mode_inc > {1'b0, cfg.max_mode}) ? 4'd0 : mode_inc[3:0];

  // announce timeout from the mode being announced
  assign beep_n   = {1'b0, mode_next} + 5'd1;
  assign unit_ms  = {1'b0, cfg.short_beep_ms} + {1'b0, cfg.beep_pause_ms};
  assign beeps_ms = (mode_next == 4'd0) ? {5'd0, cfg.long_beep_ms}
                                        : {5'd0, unit_ms} * {11'd0, beep_n};
  assign ann_sum  = {1'b0, beeps_ms} + {2'b0, cfg.selection_timeout_ms};
  assign ann_ext  = CMP_W'(ann_sum);
  assign ann_load = (ann_ext > TMAX) ? TIMER_BITS'(TMAX) : TIMER_BITS'(ann_ext);
  assign deb_load = TIMER_BITS'(cfg.debounce_ms);

  always_comb begin
    phase_next     = phase;
    countdown_next = countdown;
    mode_next      = mode_value;
    status_next    = status_reg;
    armed_next     = armed;
    do_announce    = 1'b0;
    load_debounce  = 1'b0;

    unique case (item.op)
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          if (countdown <= TIMER_BITS'(1)) begin
            countdown_next = '0;
            unique case (phase)
              PH_PRESS: begin
                if (item.pin_level) begin
                  mode_next   = (mode_value == 4'd0) ? 4'd1 : 4'd0;
                  do_announce = 1'b1;
                end else begin
                  status_next = ST_NOSEL;
                  phase_next  = PH_IDLE;
                end
              end
              PH_ANNOUNCE: begin
                if (item.pin_level) begin
                  mode_next   = mode_adv;
                  do_announce = 1'b1;
                end else begin
                  load_debounce = 1'b1;
                  phase_next    = PH_RELEASE;
                end
              end
              PH_RELEASE: begin
                if (item.pin_level) begin
                  mode_next   = mode_adv;
                  do_announce = 1'b1;
                end else begin
                  status_next = ST_NEWSEL;
                  phase_next  = PH_IDLE;
                end
              end
              default: phase_next = PH_IDLE;
            endcase
          end else begin
            countdown_next = countdown - TIMER_BITS'(1);
          end
        end
      end
      OP_PIN: begin
        if (armed) begin
          armed_next    = 1'b0;
          status_next   = ST_WAIT;
          load_debounce = 1'b1;
          phase_next    = PH_PRESS;
        end
      end
      OP_ARM: begin
        status_next = ST_SLEEP;
        armed_next  = 1'b1;
      end
      default: ;
    endcase

    if (do_announce) begin
      phase_next     = PH_ANNOUNCE;
      countdown_next = ann_load;
    end
    if (load_debounce) countdown_next = deb_load;
  end

  always_comb begin
    result.status      = status_next;
    result.mode        = mode_next;
    result.beep_start  = do_announce;
    result.beep_count  = '0;
    result.beep_on_ms  = '0;
    result.beep_gap_ms = '0;
    if (do_announce) begin
      if (mode_next == 4'd0) begin
        result.beep_count = 5'd1;
        result.beep_on_ms = cfg.long_beep_ms;
      end else begin
        result.beep_count  = beep_n;
        result.beep_on_ms  = {1'b0, cfg.short_beep_ms};
        result.beep_gap_ms = cfg.beep_pause_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      countdown  <= '0;
      mode_value <= '0;
      status_reg <= ST_SLEEP;
      armed      <= 1'b0;
    end else if (fire) begin
      phase      <= phase_next;
      countdown  <= countdown_next;
      mode_value <= mode_next;
      status_reg <= status_next;
      armed      <= armed_next;
    end
  end

  // idle is only entered through reset or an expiry, both of which clear the timer
  a_idle_timer_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> countdown == '0)
    else $error("timer running while idle");

  a_beep_enters_announce: assert property (@(posedge clk) disable iff (rst)
    fire && result.beep_start |=> phase == PH_ANNOUNCE)
    else $error("beep issued without announce phase");

  a_arm_sets: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == OP_ARM |=> armed && status_reg == ST_SLEEP)
    else $error("arm item not applied");

  a_pin_disarms: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == OP_PIN && armed |=> !armed && phase == PH_PRESS)
    else $error("pin change did not start press debounce");

endmodule
